@@ design/hkd_pkg.sv @@
// Package with shared types and constants for the HID keyboard key event differ.
package hkd_pkg;

    localparam int BYTE_W   = 8;
    localparam int IN_BYTES = 9;

    typedef enum logic {
        ACT_REPORT = 1'b0,
        ACT_CLEAR  = 1'b1
    } action_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ design/hkd_fifo.sv @@
// Small register-based queue between the front and back parts.
module hkd_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/hkd_front.sv @@
// Front part: accepts reports, keeps the held keys and builds the event masks.
module hkd_front
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  byte_t                               cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  byte_t                               report_length,
    input  byte_t                               byte_0,
    input  byte_t                               byte_1,
    input  byte_t                               byte_2,
    input  byte_t                               byte_3,
    input  byte_t                               byte_4,
    input  byte_t                               byte_5,
    input  byte_t                               byte_6,
    input  byte_t                               byte_7,
    input  byte_t                               byte_8,
    output logic                                push_valid,
    input  logic                                push_ready,
    output logic [BYTE_W+18*KEY_SLOTS-1:0]      push_data
);

    localparam int          EXT_N    = KEY_SLOTS + 3;
    localparam logic [7:0]  LEN_FULL = 8'(KEY_SLOTS + 2);
    localparam logic [7:0]  LEN_CMP  = 8'(KEY_SLOTS + 1);

    byte_t                          report_id_reg;
    byte_t                          held_reg  [KEY_SLOTS];
    byte_t                          held_next [KEY_SLOTS];
    byte_t                          in_bytes  [IN_BYTES];
    byte_t                          ext       [EXT_N];
    byte_t                          fresh     [KEY_SLOTS];
    logic                           strip;
    byte_t                          len_adj;
    logic                           len_full;
    logic                           len_ok;
    logic [1:0]                     base;
    byte_t                          mods;
    logic [KEY_SLOTS-1:0]           press_mask;
    logic [KEY_SLOTS-1:0]           release_mask;
    logic [2*KEY_SLOTS-1:0]         mask;
    logic [2*KEY_SLOTS*BYTE_W-1:0]  codes;
    logic                           accept;

    assign in_bytes[0] = byte_0;
    assign in_bytes[1] = byte_1;
    assign in_bytes[2] = byte_2;
    assign in_bytes[3] = byte_3;
    assign in_bytes[4] = byte_4;
    assign in_bytes[5] = byte_5;
    assign in_bytes[6] = byte_6;
    assign in_bytes[7] = byte_7;
    assign in_bytes[8] = byte_8;

    for (genvar j = 0; j < EXT_N; j++)
    begin : g_ext
        if (j < IN_BYTES)
        begin : g_in
            assign ext[j] = in_bytes[j];
        end
        else
        begin : g_zero
            assign ext[j] = '0;
        end
    end

    assign strip    = (report_id_reg != '0) && (report_length != '0) && (byte_0 == report_id_reg);
    assign len_adj  = report_length - {7'd0, strip};
    assign len_full = (len_adj == LEN_FULL);
    assign len_ok   = len_full || (len_adj == LEN_CMP);
    assign base     = {1'b0, strip} + (len_full ? 2'd2 : 2'd1);
    assign mods     = strip ? byte_1 : byte_0;

    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_fresh
        always_comb
        begin
            unique case (base)
                2'd1:    fresh[i] = ext[i + 1];
                2'd2:    fresh[i] = ext[i + 2];
                2'd3:    fresh[i] = ext[i + 3];
                default: fresh[i] = ext[i + 1];
            endcase
        end
    end

    always_comb
    begin
        logic hit_new;
        logic hit_old;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            hit_new = 1'b0;
            hit_old = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                hit_new = hit_new | (held_reg[j] == fresh[i]);
                hit_old = hit_old | (fresh[j] == held_reg[i]);
            end
            press_mask[i]   = (fresh[i] != '0) && !hit_new;
            release_mask[i] = (held_reg[i] != '0) && !hit_old;
        end
    end

    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_codes
        assign codes[i*BYTE_W +: BYTE_W]               = fresh[i];
        assign codes[(KEY_SLOTS+i)*BYTE_W +: BYTE_W]   = held_reg[i];
    end

    assign mask       = {release_mask, press_mask};
    assign in_stall   = !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = accept && (action_t'(action) == ACT_REPORT) && len_ok && (mask != '0);
    assign push_data  = {mods, mask, codes};

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            held_next[i] = held_reg[i];
            if (accept)
            begin
                if (action_t'(action) == ACT_CLEAR)
                begin
                    held_next[i] = '0;
                end
                else if (len_ok)
                begin
                    held_next[i] = fresh[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_id_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                report_id_reg <= cfg_data;
            end
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

@@ design/hkd_back.sv @@
// Back part: walks the event mask of one queued report and issues one event a cycle while out_stall is low.
module hkd_back
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [BYTE_W+18*KEY_SLOTS-1:0]  pop_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output byte_t                           key_code,
    output byte_t                           modifier_bits,
    output logic                            is_press,
    output logic                            last_event
);

    localparam int NEV = 2 * KEY_SLOTS;
    localparam int CDW = NEV * BYTE_W;

    logic [NEV-1:0] mask_reg;
    logic [CDW-1:0] codes_reg;
    byte_t          mods_reg;
    logic           out_valid_reg;
    byte_t          key_code_reg;
    byte_t          modifier_bits_reg;
    logic           is_press_reg;
    logic           last_event_reg;
    logic [NEV-1:0] low_bit;
    logic [NEV-1:0] rest;
    byte_t          sel_code;
    logic           busy;
    logic           can_load;
    logic           issue;
    logic           last;
    logic           do_pop;

    assign low_bit  = mask_reg & (~mask_reg + NEV'(1));
    assign rest     = mask_reg & ~low_bit;
    assign last     = (rest == '0);
    assign busy     = (mask_reg != '0);
    assign can_load = !out_valid_reg || !out_stall;
    assign issue    = busy && can_load;
    assign pop_ready = !busy || (issue && last);
    assign do_pop   = pop_valid && pop_ready;

    always_comb
    begin
        sel_code = '0;
        for (int i = 0; i < NEV; i++)
        begin
            sel_code = sel_code | (codes_reg[i*BYTE_W +: BYTE_W] & {BYTE_W{low_bit[i]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                mask_reg <= pop_data[CDW +: NEV];
            end
            else if (issue)
            begin
                mask_reg <= rest;
            end
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            codes_reg <= pop_data[CDW-1:0];
            mods_reg  <= pop_data[CDW+NEV +: BYTE_W];
        end
        if (issue)
        begin
            key_code_reg      <= sel_code;
            modifier_bits_reg <= mods_reg;
            is_press_reg      <= |low_bit[KEY_SLOTS-1:0];
            last_event_reg    <= last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_code      = key_code_reg;
    assign modifier_bits = modifier_bits_reg;
    assign is_press      = is_press_reg;
    assign last_event    = last_event_reg;

endmodule

@@ design/hid_keyboard_report_key_event_diff_unit.sv @@
// Top level of the HID keyboard report to key event differ.
//
//   Channel   Handshake              Carries
//   cfg       cfg_valid / cfg_ready  report_id
//   in        in_valid / in_stall    action, report_length, byte_0 .. byte_8
//   out       out_valid / out_stall  key_code, modifier_bits, is_press, last_event
//
// A report is classified in the cycle it is accepted and, if it yields events, its event mask is queued.
// The back part issues one event per cycle while out_stall is low; a report yields up to
// 2*KEY_SLOTS events, and the next report follows its last event without a gap.
// Reset clears the held keys, the report ID and the queue; no clearing pass is needed.
// The input stalls only when the two-entry queue is full.
module hid_keyboard_report_key_event_diff_unit
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  byte_t report_id,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  action,
    input  byte_t report_length,
    input  byte_t byte_0,
    input  byte_t byte_1,
    input  byte_t byte_2,
    input  byte_t byte_3,
    input  byte_t byte_4,
    input  byte_t byte_5,
    input  byte_t byte_6,
    input  byte_t byte_7,
    input  byte_t byte_8,
    output logic  out_valid,
    input  logic  out_stall,
    output byte_t key_code,
    output byte_t modifier_bits,
    output logic  is_press,
    output logic  last_event
);

    localparam int ENTRY_W = BYTE_W + 18 * KEY_SLOTS;
    localparam int Q_DEPTH = 2;

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    assign cfg_ready = 1'b1;

    hkd_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (report_id),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .report_length (report_length),
        .byte_0        (byte_0),
        .byte_1        (byte_1),
        .byte_2        (byte_2),
        .byte_3        (byte_3),
        .byte_4        (byte_4),
        .byte_5        (byte_5),
        .byte_6        (byte_6),
        .byte_7        (byte_7),
        .byte_8        (byte_8),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    hkd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hkd_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_code      (key_code),
        .modifier_bits (modifier_bits),
        .is_press      (is_press),
        .last_event    (last_event)
    );

endmodule
